>>> src/mmfq_pkg.sv
package mmfq_pkg;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TRAIN_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BATCH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS_QUANT = 2'd3;

  // Register reset values
  localparam logic        TRAIN_MODE_RST   = 1'b1;
  localparam logic        FIRST_BATCH_RST  = 1'b1;
  localparam logic [15:0] DECAY_FACTOR_RST = 16'd58982;
  localparam logic        BYPASS_QUANT_RST = 1'b0;

  // Fixed arithmetic constants
  localparam int          DECAY_W        = 16;
  localparam logic [16:0] DECAY_ONE      = 17'h10000;   // 1.0 in Q0.16
  localparam int          ROUND_HALF     = 32768;       // 0.5 in Q0.16
  localparam int          MUL_B_W        = 18;
  localparam int          CODE_W         = 8;
  localparam logic [7:0]  CODE_MAX       = 8'd255;
  localparam int          DEQ_BIAS       = 127;
  localparam int          CODE_SAT_STEPS = 9;

  // Divider control and status
  localparam int STEP_W = 6;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> src/mmfq_if.sv
interface mmfq_in_if #(parameter int SAMPLE_WIDTH = 16) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

interface mmfq_out_if #(parameter int SAMPLE_WIDTH = 16) ();
  logic                           valid;
  logic                           ready;
  logic [7:0]                     quant_code;
  logic signed [SAMPLE_WIDTH-1:0] dequant_value;
  logic                           final_result;
  logic                           overflow_flag;

  modport source (output valid, quant_code, dequant_value, final_result, overflow_flag,
                  input ready);
  modport sink (input valid, quant_code, dequant_value, final_result, overflow_flag,
                output ready);
endinterface

>>> src/mmfq_ram.sv
module mmfq_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/mmfq_mul.sv
module mmfq_mul #(
  parameter int A_W = 17,
  parameter int B_W = 18
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] prod
);

  // Register the product for the next step of the sequence
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

>>> src/mmfq_div.sv
module mmfq_div #(
  parameter int DW = 26,
  parameter int QW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mmfq_pkg::div_ctrl_t   ctrl,
  input  logic [DW-1:0]         dividend,
  input  logic [DW-1:0]         divisor,
  output mmfq_pkg::div_stat_t   stat,
  output logic [QW-1:0]         quotient
);

  logic [DW-1:0]               rem;
  logic [DW-1:0]               dvs;
  logic [QW-1:0]               q;
  logic [mmfq_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic                        ge;
  logic [DW-1:0]               diff;

  // Compare and subtract against the aligned divisor
  assign ge   = (rem >= dvs);
  assign diff = rem - dvs;

  // Count steps; pulse done after the last quotient bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mmfq_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle, divisor shifted down each step
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= dividend;
      dvs <= divisor;
      q   <= '0;
    end else if (busy) begin
      rem <= ge ? diff : rem;
      dvs <= dvs >> 1;
      q   <= {q[QW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = q;

endmodule

>>> src/minmax_fake_quant_ema_range.sv
// Min/max fake quantizer with a moving-average range.
//
// Input channel in_ch carries one signed Q7.8 sample per request; a request
// with last_sample set closes the tensor. Every request is taken in the cycle
// it is offered while the block is loading. Samples past MAX_ELEMENTS are
// dropped and the whole run is then flagged with overflow_flag.
// After the closing request the block settles the range, blending it with
// the running range when training after the first batch, then emits every
// stored sample on out_ch in arrival order, final_result on the last one.
// in_ch is not ready from the closing request until the final result is taken.
// In bypass, with an empty range or for a sample below the range a result
// skips the division; otherwise the divider yields the nine code quotient
// bits one per cycle, the shared multiplier forms code times range, and one
// shift-add pass per cycle divides that plus a bias of 127 by 255 for the
// dequantized value. A stalled receiver holds the result and the sequencer
// with it. Configuration is written through cfg_we/cfg_index/cfg_data, by
// the user only while idle; the block does not enforce it. Reset (rst,
// synchronous) empties the buffer, clears the running range and restores the
// register defaults; the sample memory needs no clearing.
module minmax_fake_quant_ema_range #(
  parameter int MAX_ELEMENTS = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mmfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmfq_pkg::CFG_W-1:0]     cfg_data,
  mmfq_in_if.sink                        in_ch,
  mmfq_out_if.source                     out_ch
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int DW = W + 10;
  localparam int QW = mmfq_pkg::CODE_SAT_STEPS;
  localparam int PW = W + 1 + mmfq_pkg::MUL_B_W;
  localparam int NW = W + 11;
  localparam int XW = W + 8;
  localparam int DEQ_ITERS = (W + 7) / 8 + 1;
  localparam int DCW = $clog2(DEQ_ITERS + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_PREP  = 4'd5;
  localparam logic [3:0] S_DIV1  = 4'd6;
  localparam logic [3:0] S_CMUL  = 4'd7;
  localparam logic [3:0] S_DLOAD = 4'd8;
  localparam logic [3:0] S_DIV2  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]                      state;
  logic                            train_mode;
  logic                            first_batch;
  logic [mmfq_pkg::DECAY_W-1:0]    decay_factor;
  logic                            bypass_quant;
  logic [CW-1:0]                   fill_count;
  logic [CW-1:0]                   idx;
  logic                            dropped;
  logic [1:0]                      bsel;
  logic signed [W-1:0]             batch_min;
  logic signed [W-1:0]             batch_max;
  logic signed [W-1:0]             running_min;
  logic signed [W-1:0]             running_max;
  logic signed [W-1:0]             lo_r;
  logic signed [W-1:0]             hi_r;
  logic signed [W:0]               range_r;
  logic signed [PW-1:0]            acc;
  logic [7:0]                      code_r;
  logic signed [W-1:0]             deq_r;
  logic [W-1:0]                    deq_q;
  logic [DCW-1:0]                  deq_cnt;

  logic                            accept;
  logic                            full;
  logic signed [W-1:0]             x;
  logic signed [W-1:0]             bmin_upd;
  logic signed [W-1:0]             bmax_upd;
  logic [W-1:0]                    rd_data;
  logic signed [W-1:0]             v;
  logic signed [W:0]               diff;
  logic signed [NW-1:0]            num;
  logic                            range_pos;
  logic                            quantize;
  logic                            last_out;

  logic signed [W:0]               mul_a;
  logic signed [mmfq_pkg::MUL_B_W-1:0] mul_b;
  logic                            mul_en;
  logic signed [PW-1:0]            prod;
  logic signed [PW-1:0]            acc_sum;
  logic signed [W-1:0]             blend_res;

  mmfq_pkg::div_ctrl_t             div_ctrl;
  mmfq_pkg::div_stat_t             div_stat;
  logic [DW-1:0]                   div_dividend;
  logic [DW-1:0]                   div_divisor;
  logic [QW-1:0]                   div_q;
  logic [7:0]                      code_sat;
  logic [XW-1:0]                   deq_x;
  logic [XW-1:0]                   deq_acc;
  logic [W-1:0]                    deq_q_next;
  logic [W-1:0]                    deq_sum;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      train_mode   <= mmfq_pkg::TRAIN_MODE_RST;
      first_batch  <= mmfq_pkg::FIRST_BATCH_RST;
      decay_factor <= mmfq_pkg::DECAY_FACTOR_RST;
      bypass_quant <= mmfq_pkg::BYPASS_QUANT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmfq_pkg::REG_TRAIN_MODE:   train_mode   <= cfg_data[0];
        mmfq_pkg::REG_FIRST_BATCH:  first_batch  <= cfg_data[0];
        mmfq_pkg::REG_DECAY_FACTOR: decay_factor <= cfg_data[mmfq_pkg::DECAY_W-1:0];
        mmfq_pkg::REG_BYPASS_QUANT: bypass_quant <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Load side: take a request, track the batch range
  assign in_ch.ready = (state == S_LOAD);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (fill_count == CW'(MAX_ELEMENTS));
  assign x           = in_ch.sample;

  always_comb begin
    if (full) begin
      bmin_upd = batch_min;
      bmax_upd = batch_max;
    end else if (fill_count == '0) begin
      bmin_upd = x;
      bmax_upd = x;
    end else begin
      bmin_upd = (x < batch_min) ? x : batch_min;
      bmax_upd = (x > batch_max) ? x : batch_max;
    end
  end

  mmfq_ram #(
    .WIDTH (W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (fill_count[AW-1:0]),
    .wdata (x),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  // Shared multiplier: blend terms, then code times range
  always_comb begin
    if (state == S_CMUL) begin
      mul_a = range_r;
      mul_b = $signed({{(mmfq_pkg::MUL_B_W - mmfq_pkg::CODE_W){1'b0}}, code_r});
    end else if (!bsel[0]) begin
      mul_a = bsel[1] ? {batch_min[W-1], batch_min} : {batch_max[W-1], batch_max};
      mul_b = $signed({1'b0, mmfq_pkg::DECAY_ONE - {1'b0, decay_factor}});
    end else begin
      mul_a = bsel[1] ? {running_min[W-1], running_min} : {running_max[W-1], running_max};
      mul_b = $signed({2'b00, decay_factor});
    end
  end

  assign mul_en = (state == S_MUL) || (state == S_CMUL);

  mmfq_mul #(
    .A_W (W + 1),
    .B_W (mmfq_pkg::MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Blend result: floor of the rounded sum in Q0.16
  assign acc_sum   = acc + prod;
  assign blend_res = acc_sum[W+15:16];

  // Element numerator for the code division
  assign v         = $signed(rd_data);
  assign diff      = {v[W-1], v} - {lo_r[W-1], lo_r};
  assign num       = (NW'(diff) <<< 9) - (NW'(diff) <<< 1) + NW'(range_r);
  assign range_pos = !range_r[W] && (range_r != '0);
  assign quantize  = !bypass_quant && range_pos && !num[NW-1];

  // Divider: code quotient against the aligned range
  always_comb begin
    div_dividend   = num[DW-1:0];
    div_divisor    = DW'($unsigned(range_r)) << 9;
    div_ctrl.steps = mmfq_pkg::STEP_W'(mmfq_pkg::CODE_SAT_STEPS);
    div_ctrl.start = (state == S_PREP) && quantize;
  end

  mmfq_div #(
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign code_sat = div_q[8] ? mmfq_pkg::CODE_MAX : div_q[7:0];

  // Divide code times range plus bias by 255: q = (x + q + 1) >> 8,
  // iterated from zero, settles on the exact floor
  assign deq_x      = prod[XW-1:0] + XW'(mmfq_pkg::DEQ_BIAS);
  assign deq_acc    = deq_x + XW'(deq_q) + XW'(1);
  assign deq_q_next = deq_acc[XW-1:8];
  assign deq_sum    = $unsigned(lo_r) + deq_q_next;
  assign last_out   = ((idx + CW'(1)) == fill_count);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      fill_count  <= '0;
      idx         <= '0;
      dropped     <= 1'b0;
      bsel        <= '0;
      deq_cnt     <= '0;
      running_min <= '0;
      running_max <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (!full) begin
              fill_count <= fill_count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (in_ch.last_sample) begin
              bsel  <= '0;
              state <= (train_mode && !first_batch) ? S_MUL : S_SETUP;
            end
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          bsel  <= bsel + 2'd1;
          state <= (bsel == 2'd3) ? S_SETUP : S_MUL;
        end
        S_SETUP: begin
          if (train_mode) begin
            running_min <= lo_r;
            running_max <= hi_r;
          end
          idx   <= '0;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_PREP;
        end
        S_PREP: begin
          state <= quantize ? S_DIV1 : S_OUT;
        end
        S_DIV1: begin
          if (div_stat.done) begin
            state <= S_CMUL;
          end
        end
        S_CMUL: begin
          state <= S_DLOAD;
        end
        S_DLOAD: begin
          deq_cnt <= DCW'(DEQ_ITERS);
          state   <= S_DIV2;
        end
        S_DIV2: begin
          deq_cnt <= deq_cnt - DCW'(1);
          if (deq_cnt == DCW'(1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (last_out) begin
              fill_count <= '0;
              dropped    <= 1'b0;
              state      <= S_LOAD;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          batch_min <= bmin_upd;
          batch_max <= bmax_upd;
          if (in_ch.last_sample) begin
            lo_r <= train_mode ? bmin_upd : running_min;
            hi_r <= train_mode ? bmax_upd : running_max;
          end
        end
      end
      S_ACC: begin
        if (!bsel[0]) begin
          acc <= prod + PW'(mmfq_pkg::ROUND_HALF);
        end else if (!bsel[1]) begin
          hi_r <= blend_res;
        end else begin
          lo_r <= blend_res;
        end
      end
      S_SETUP: begin
        range_r <= {hi_r[W-1], hi_r} - {lo_r[W-1], lo_r};
      end
      S_PREP: begin
        if (bypass_quant) begin
          code_r <= '0;
          deq_r  <= v;
        end else if (!quantize) begin
          code_r <= '0;
          deq_r  <= lo_r;
        end
      end
      S_DIV1: begin
        if (div_stat.done) begin
          code_r <= code_sat;
        end
      end
      S_DLOAD: begin
        deq_q <= '0;
      end
      S_DIV2: begin
        deq_q <= deq_q_next;
        if (deq_cnt == DCW'(1)) begin
          deq_r <= $signed(deq_sum);
        end
      end
      default: ;
    endcase
  end

  // Result port
  assign out_ch.valid         = (state == S_OUT);
  assign out_ch.quant_code    = code_r;
  assign out_ch.dequant_value = deq_r;
  assign out_ch.final_result  = last_out;
  assign out_ch.overflow_flag = dropped;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_ELEMENTS))
    else $error("fill count past capacity");

  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (fill_count != '0) && (idx < fill_count))
    else $error("result emitted outside the stored run");

  a_done_owner: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV1))
    else $error("divider finished outside a division step");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_code_needs_range: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.quant_code != '0)) |-> !bypass_quant && range_pos)
    else $error("nonzero code without a positive range");

  a_run_closes: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.final_result) |=>
      (fill_count == '0) && in_ch.ready && !dropped)
    else $error("run did not close after the final result");

endmodule
